// ===== hw/rtl/lct_pkg.sv =====
// Shared types and constants for the increasing-subsequence counter.
// Used by the channel interfaces, the merge unit, the top level and the checker.
// No dependencies.
package lct_pkg;

   // Default size of the value domain (number of leaves in the tree).
   localparam int DOMAIN_SIZE_DEF = 1024;

   // Field widths on the channels.
   localparam int VALUE_W   = 10;
   localparam int LEN_OUT_W = 11;
   localparam int WAYS_W    = 30;

   // Counts are kept modulo this prime.
   localparam logic [WAYS_W-1:0] COUNT_MOD = 30'd1000000007;

   // Width of the generation tag stored with every tree node.
   localparam int EPOCH_W = 4;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_LEAF_RD,
      ST_LEAF_WR,
      ST_UP,
      ST_RESP
   } lct_state_type;

endpackage

// ===== hw/rtl/lct_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
// Depends on lct_pkg for the field widths.
interface lct_req_if import lct_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic               start_new;

   modport source (output valid, output value, output start_new, input ready);
   modport sink   (input valid, input value, input start_new, output ready);
endinterface

interface lct_rsp_if import lct_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [LEN_OUT_W-1:0] len_here;
   logic [WAYS_W-1:0]    ways_here;
   logic [LEN_OUT_W-1:0] best_len;
   logic [WAYS_W-1:0]    best_ways;

   modport source (output valid, output len_here, output ways_here,
                   output best_len, output best_ways, input ready);
   modport sink   (input valid, input len_here, input ways_here,
                   input best_len, input best_ways, output ready);
endinterface

// ===== hw/rtl/lct_tree_mem.sv =====
// Single-port-write, single-port-read node store for the segment tree.
// Read data is registered; depends on nothing else.
module lct_tree_mem #(
   parameter int DEPTH  = 2048,
   parameter int WIDTH  = 45,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/lct_combine.sv =====
// Shared node-merge unit: keeps the longer length, or adds counts modulo the prime on a tie.
// Depends on lct_pkg for the count width and modulus.
module lct_combine import lct_pkg::*; #(
   parameter int LEN_W = 11
) (
   input  logic [LEN_W-1:0]  a_len,
   input  logic [WAYS_W-1:0] a_cnt,
   input  logic [LEN_W-1:0]  b_len,
   input  logic [WAYS_W-1:0] b_cnt,
   output logic [LEN_W-1:0]  y_len,
   output logic [WAYS_W-1:0] y_cnt
);

   logic [WAYS_W:0] sum;
   logic [WAYS_W:0] sum_red;

   // Both counts are below the modulus, so one conditional subtract reduces the sum.
   always_comb begin
      sum     = {1'b0, a_cnt} + {1'b0, b_cnt};
      sum_red = sum - {1'b0, COUNT_MOD};
      if (a_len > b_len) begin
         y_len = a_len;
         y_cnt = a_cnt;
      end else if (a_len < b_len) begin
         y_len = b_len;
         y_cnt = b_cnt;
      end else begin
         y_len = a_len;
         y_cnt = (sum >= {1'b0, COUNT_MOD}) ? sum_red[WAYS_W-1:0] : sum[WAYS_W-1:0];
      end
   end

endmodule

// ===== hw/rtl/lis_count_segment_tree.sv =====
// One item is in work at a time: the request side is ready only while idle, so a new request
// is taken only after the previous result has been handed to the output register.
// The single read port of the node store paces the work: prefix walk, leaf merge, path
// update and root walk each read one node at a time.
// Reset is synchronous and active high; it starts a clearing pass over all NODES entries
// with the request side not ready, and the same pass runs after every 15th start_new.
module lis_count_segment_tree import lct_pkg::*; #(
   parameter int DOMAIN_SIZE = DOMAIN_SIZE_DEF
) (
   input logic       clock,
   input logic       reset,
   lct_req_if.sink   req_bus,
   lct_rsp_if.source rsp_bus
);

   localparam int NODES   = 2 * DOMAIN_SIZE;
   localparam int ADDR_W  = $clog2(NODES);
   localparam int PTR_W   = $clog2(NODES + 1);
   localparam int IDX_W   = $clog2(DOMAIN_SIZE);
   localparam int LEN_W   = $clog2(DOMAIN_SIZE + 1);
   localparam int ENTRY_W = EPOCH_W + LEN_W + WAYS_W;

   localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
   localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;
   localparam logic [ADDR_W-1:0]  CLR_LAST    = ADDR_W'(NODES - 1);
   localparam logic [ADDR_W-1:0]  ROOT_ADDR   = ADDR_W'(1);

   // Control state.
   lct_state_type       state_ff, state_in;
   logic [EPOCH_W-1:0]  epoch_ff, epoch_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic                item_pend_ff, item_pend_in;
   logic                pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic [IDX_W-1:0]     pos_ff, pos_in;
   logic [PTR_W-1:0]     l_ff, l_in;
   logic [PTR_W-1:0]     r_ff, r_in;
   logic                 best_phase_ff, best_phase_in;
   logic [LEN_W-1:0]     acc_len_ff, acc_len_in;
   logic [WAYS_W-1:0]    acc_cnt_ff, acc_cnt_in;
   logic [LEN_W-1:0]     here_len_ff, here_len_in;
   logic [WAYS_W-1:0]    here_cnt_ff, here_cnt_in;
   logic [LEN_W-1:0]     cur_len_ff, cur_len_in;
   logic [WAYS_W-1:0]    cur_cnt_ff, cur_cnt_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;
   logic [LEN_OUT_W-1:0] rsp_len_ff, rsp_len_in;
   logic [WAYS_W-1:0]    rsp_ways_ff, rsp_ways_in;
   logic [LEN_OUT_W-1:0] rsp_best_len_ff, rsp_best_len_in;
   logic [WAYS_W-1:0]    rsp_best_ways_ff, rsp_best_ways_in;

   // Node store access.
   logic               mem_wr_en;
   logic [ADDR_W-1:0]  mem_wr_addr;
   logic [ENTRY_W-1:0] mem_wr_data;
   logic               mem_rd_en;
   logic [ADDR_W-1:0]  mem_rd_addr;
   logic [ENTRY_W-1:0] mem_rd_data;
   logic [EPOCH_W-1:0] rd_tag;
   logic [LEN_W-1:0]   rd_len;
   logic [WAYS_W-1:0]  rd_cnt;

   // Shared merge unit.
   logic [LEN_W-1:0]  cmb_a_len;
   logic [WAYS_W-1:0] cmb_a_cnt;
   logic [LEN_W-1:0]  cmb_y_len;
   logic [WAYS_W-1:0] cmb_y_cnt;

   // Miscellaneous decode.
   logic              req_fire;
   logic [IDX_W-1:0]  req_pos;
   logic [IDX_W-1:0]  init_pos;
   logic              init_query;
   logic              init_best;
   logic              walk_go;
   logic              rsp_load;
   logic [ADDR_W-1:0] leaf_addr;
   logic [ADDR_W-1:0] up_parent;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign walk_go       = (l_ff < r_ff);
   assign leaf_addr     = ADDR_W'(DOMAIN_SIZE) + ADDR_W'(pos_ff);
   assign up_parent     = idx_ff >> 1;
   assign rsp_load      = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_bus.ready);

   // Values beyond the domain fall onto the top leaf.
   always_comb begin
      if (32'(req_bus.value) >= 32'(DOMAIN_SIZE)) begin
         req_pos = IDX_W'(DOMAIN_SIZE - 1);
      end else begin
         req_pos = IDX_W'(req_bus.value);
      end
   end

   // Node read-back; an entry tagged with an older generation reads as empty.
   assign rd_tag = mem_rd_data[ENTRY_W-1 -: EPOCH_W];
   assign rd_len = (rd_tag == epoch_ff) ? mem_rd_data[LEN_W+WAYS_W-1 : WAYS_W] : '0;
   assign rd_cnt = (rd_tag == epoch_ff) ? mem_rd_data[WAYS_W-1:0] : '0;

   lct_tree_mem #(
      .DEPTH (NODES),
      .WIDTH (ENTRY_W)
   ) u_tree_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // First operand of the merge unit follows the phase; the second is always the node read.
   always_comb begin
      case (state_ff)
         ST_LEAF_WR: begin
            cmb_a_len = here_len_ff;
            cmb_a_cnt = here_cnt_ff;
         end
         ST_UP: begin
            cmb_a_len = cur_len_ff;
            cmb_a_cnt = cur_cnt_ff;
         end
         default: begin
            cmb_a_len = acc_len_ff;
            cmb_a_cnt = acc_cnt_ff;
         end
      endcase
   end

   lct_combine #(
      .LEN_W (LEN_W)
   ) u_combine (
      .a_len (cmb_a_len),
      .a_cnt (cmb_a_cnt),
      .b_len (rd_len),
      .b_cnt (rd_cnt),
      .y_len (cmb_y_len),
      .y_cnt (cmb_y_cnt)
   );

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == CLR_LAST) begin
               state_in = item_pend_ff ? ST_WALK : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.start_new && (epoch_ff == EPOCH_LAST)) begin
                  state_in = ST_CLEAR;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (!walk_go) begin
               state_in = best_phase_ff ? ST_RESP : ST_LEAF_RD;
            end
         end
         ST_LEAF_RD: state_in = ST_LEAF_WR;
         ST_LEAF_WR: state_in = ST_UP;
         ST_UP: begin
            if (up_parent == ROOT_ADDR) begin
               state_in = ST_WALK;
            end
         end
         ST_RESP: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // Datapath and store control for each state.
   always_comb begin
      epoch_in         = epoch_ff;
      clr_in           = clr_ff;
      item_pend_in     = item_pend_ff;
      pend_in          = 1'b0;
      rsp_valid_in     = rsp_valid_ff;
      pos_in           = pos_ff;
      l_in             = l_ff;
      r_in             = r_ff;
      best_phase_in    = best_phase_ff;
      acc_len_in       = acc_len_ff;
      acc_cnt_in       = acc_cnt_ff;
      here_len_in      = here_len_ff;
      here_cnt_in      = here_cnt_ff;
      cur_len_in       = cur_len_ff;
      cur_cnt_in       = cur_cnt_ff;
      idx_in           = idx_ff;
      rsp_len_in       = rsp_len_ff;
      rsp_ways_in      = rsp_ways_ff;
      rsp_best_len_in  = rsp_best_len_ff;
      rsp_best_ways_in = rsp_best_ways_ff;
      mem_wr_en        = 1'b0;
      mem_wr_addr      = '0;
      mem_wr_data      = '0;
      mem_rd_en        = 1'b0;
      mem_rd_addr      = '0;
      init_query       = 1'b0;
      init_best        = 1'b0;
      init_pos         = pos_ff;

      // The output register empties when its beat is taken.
      if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         // Sweep the store, tagging every node as belonging to no generation.
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = {EPOCH_NONE, {(LEN_W + WAYS_W){1'b0}}};
            clr_in      = clr_ff + ADDR_W'(1);
            if (clr_ff == CLR_LAST) begin
               clr_in   = '0;
               epoch_in = EPOCH_FIRST;
               if (item_pend_ff) begin
                  item_pend_in = 1'b0;
                  init_query   = 1'b1;
               end
            end
         end

         // Take a request beat; a new sequence moves to the next generation.
         ST_IDLE: begin
            if (req_fire) begin
               pos_in   = req_pos;
               init_pos = req_pos;
               if (req_bus.start_new && (epoch_ff == EPOCH_LAST)) begin
                  item_pend_in = 1'b1;
               end else begin
                  if (req_bus.start_new) begin
                     epoch_in = epoch_ff + EPOCH_W'(1);
                  end
                  init_query = 1'b1;
               end
            end
         end

         // Bottom-up range walk: when both edges need a node, the left one is read first.
         ST_WALK: begin
            if (pend_ff) begin
               acc_len_in = cmb_y_len;
               acc_cnt_in = cmb_y_cnt;
            end
            if (walk_go) begin
               if (l_ff[0]) begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ADDR_W'(l_ff);
                  pend_in     = 1'b1;
                  if (r_ff[0]) begin
                     l_in = l_ff + PTR_W'(1);
                  end else begin
                     l_in = (l_ff + PTR_W'(1)) >> 1;
                     r_in = r_ff >> 1;
                  end
               end else begin
                  if (r_ff[0]) begin
                     mem_rd_en   = 1'b1;
                     mem_rd_addr = ADDR_W'(r_ff - PTR_W'(1));
                     pend_in     = 1'b1;
                  end
                  l_in = l_ff >> 1;
                  r_in = r_ff >> 1;
               end
            end
         end

         // Form the length and count ending at this element and fetch its leaf.
         ST_LEAF_RD: begin
            if (acc_len_ff == '0) begin
               here_len_in = LEN_W'(1);
               here_cnt_in = WAYS_W'(1);
            end else begin
               here_len_in = acc_len_ff + LEN_W'(1);
               here_cnt_in = acc_cnt_ff;
            end
            mem_rd_en   = 1'b1;
            mem_rd_addr = leaf_addr;
         end

         // Merge into the leaf and fetch its sibling for the first parent.
         ST_LEAF_WR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = leaf_addr;
            mem_wr_data = {epoch_ff, cmb_y_len, cmb_y_cnt};
            cur_len_in  = cmb_y_len;
            cur_cnt_in  = cmb_y_cnt;
            idx_in      = leaf_addr;
            mem_rd_en   = 1'b1;
            mem_rd_addr = leaf_addr ^ ADDR_W'(1);
         end

         // Rebuild one ancestor a cycle while the next sibling is read.
         ST_UP: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = up_parent;
            mem_wr_data = {epoch_ff, cmb_y_len, cmb_y_cnt};
            cur_len_in  = cmb_y_len;
            cur_cnt_in  = cmb_y_cnt;
            idx_in      = up_parent;
            mem_rd_en   = 1'b1;
            mem_rd_addr = up_parent ^ ADDR_W'(1);
            if (up_parent == ROOT_ADDR) begin
               init_best = 1'b1;
            end
         end

         // Hand the result to the output register once it is free.
         ST_RESP: begin
            if (rsp_load) begin
               rsp_valid_in     = 1'b1;
               rsp_len_in       = LEN_OUT_W'(here_len_ff);
               rsp_ways_in      = here_cnt_ff;
               rsp_best_len_in  = LEN_OUT_W'(acc_len_ff);
               rsp_best_ways_in = acc_cnt_ff;
            end
         end

         default: begin
            clr_in = '0;
         end
      endcase

      // Start of the prefix walk over values below the element.
      if (init_query) begin
         l_in          = PTR_W'(DOMAIN_SIZE);
         r_in          = PTR_W'(DOMAIN_SIZE) + PTR_W'(init_pos);
         acc_len_in    = '0;
         acc_cnt_in    = '0;
         best_phase_in = 1'b0;
      end

      // Start of the walk over the whole domain.
      if (init_best) begin
         l_in          = PTR_W'(DOMAIN_SIZE);
         r_in          = PTR_W'(NODES);
         acc_len_in    = '0;
         acc_cnt_in    = '0;
         best_phase_in = 1'b1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         epoch_ff     <= EPOCH_NONE;
         clr_ff       <= '0;
         item_pend_ff <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         epoch_ff     <= epoch_in;
         clr_ff       <= clr_in;
         item_pend_ff <= item_pend_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff           <= pos_in;
      l_ff             <= l_in;
      r_ff             <= r_in;
      best_phase_ff    <= best_phase_in;
      acc_len_ff       <= acc_len_in;
      acc_cnt_ff       <= acc_cnt_in;
      here_len_ff      <= here_len_in;
      here_cnt_ff      <= here_cnt_in;
      cur_len_ff       <= cur_len_in;
      cur_cnt_ff       <= cur_cnt_in;
      idx_ff           <= idx_in;
      rsp_len_ff       <= rsp_len_in;
      rsp_ways_ff      <= rsp_ways_in;
      rsp_best_len_ff  <= rsp_best_len_in;
      rsp_best_ways_ff <= rsp_best_ways_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.len_here  = rsp_len_ff;
   assign rsp_bus.ways_here = rsp_ways_ff;
   assign rsp_bus.best_len  = rsp_best_len_ff;
   assign rsp_bus.best_ways = rsp_best_ways_ff;

endmodule

// ===== hw/rtl/lct_checker.sv =====
// Port-level checker for lis_count_segment_tree, attached by the bind at the end of the file.
// Depends on lct_pkg for field widths and the modulus.
module lct_checker import lct_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [LEN_OUT_W-1:0] len_here,
   input logic [WAYS_W-1:0]    ways_here,
   input logic [LEN_OUT_W-1:0] best_len,
   input logic [WAYS_W-1:0]    best_ways
);

   // A response beat that is not taken stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat withdrawn before it was taken");

   // One item at a time: after a request beat the block is busy.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request side ready straight after a request beat");

   // The length ending here is never zero, and the overall best is never shorter than it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (len_here != '0) && (best_len >= len_here))
      else $error("best length below the length ending at this element");

   // Counts are fully reduced.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (ways_here < COUNT_MOD) && (best_ways < COUNT_MOD))
      else $error("count not reduced modulo the prime");

endmodule

bind lis_count_segment_tree lct_checker u_lct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .len_here  (rsp_bus.len_here),
   .ways_here (rsp_bus.ways_here),
   .best_len  (rsp_bus.best_len),
   .best_ways (rsp_bus.best_ways)
);

// ===== test/lis_count_segment_tree_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for lis_count_segment_tree: ranked values go in, and the block
// returns the length and count of increasing subsequences ending at each value.
// Depends on lct_pkg, lct_req_if / lct_rsp_if and the block itself.
module lis_count_segment_tree_tb;
   import lct_pkg::*;

   localparam int TOTAL_ITEMS  = 1420;
   localparam int CALM_FROM    = 500;
   localparam int CALM_TO      = 700;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int PAUSE_AT     = 1000;
   localparam int DRAIN_CYCLES = 60;
   localparam int CYCLE_LIMIT  = 1000000;

   typedef struct packed {
      logic [LEN_OUT_W-1:0] len_here;
      logic [WAYS_W-1:0]    ways_here;
      logic [LEN_OUT_W-1:0] best_len;
      logic [WAYS_W-1:0]    best_ways;
   } lis_result_type;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               start_new;
      logic               known;
      lis_result_type     result;
   } stim_row_type;

   // Directed rows. Where known is set, the result is typed in; otherwise it is predicted.
   localparam int DIRECTED_COUNT = 22;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      '{10'd0,    1'b1, 1'b1, '{11'd1, 30'd1, 11'd1, 30'd1}},
      '{10'd1023, 1'b0, 1'b1, '{11'd2, 30'd1, 11'd2, 30'd1}},
      '{10'd1023, 1'b0, 1'b1, '{11'd2, 30'd1, 11'd2, 30'd2}},
      '{10'd0,    1'b0, 1'b1, '{11'd1, 30'd1, 11'd2, 30'd2}},
      '{10'd512,  1'b1, 1'b1, '{11'd1, 30'd1, 11'd1, 30'd1}},
      '{10'd511,  1'b0, 1'b1, '{11'd1, 30'd1, 11'd1, 30'd2}},
      '{10'd513,  1'b0, 1'b1, '{11'd2, 30'd2, 11'd2, 30'd2}},
      '{10'd1023, 1'b1, 1'b1, '{11'd1, 30'd1, 11'd1, 30'd1}},
      '{10'd1023, 1'b0, 1'b1, '{11'd1, 30'd1, 11'd1, 30'd2}},
      '{10'd0,    1'b0, 1'b1, '{11'd1, 30'd1, 11'd1, 30'd3}},
      '{10'h001,  1'b0, 1'b0, '0},
      '{10'h055,  1'b0, 1'b0, '0},
      '{10'h155,  1'b0, 1'b0, '0},
      '{10'h2AA,  1'b0, 1'b0, '0},
      '{10'h3FE,  1'b0, 1'b0, '0},
      '{10'h3FF,  1'b0, 1'b0, '0},
      '{10'h200,  1'b0, 1'b0, '0},
      '{10'h100,  1'b0, 1'b0, '0},
      '{10'h100,  1'b0, 1'b0, '0},
      '{10'h3FF,  1'b1, 1'b0, '0},
      '{10'h000,  1'b0, 1'b0, '0},
      '{10'h2AA,  1'b1, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset;

   lct_req_if req_bus ();
   lct_rsp_if rsp_bus ();

   lis_count_segment_tree uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predictor state: best length and count per leaf of the value domain.
   int unsigned       leaf_len  [DOMAIN_SIZE_DEF];
   logic [WAYS_W-1:0] leaf_ways [DOMAIN_SIZE_DEF];

   lis_result_type lis_expected [$];
   int             items_sent  = 0;
   int             error_count = 0;
   int             cycle_count = 0;
   bit             calm;

   // Neither side idles while the item count is inside the calm window.
   assign calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic logic [WAYS_W-1:0] add_ways(input logic [WAYS_W-1:0] a,
                                                  input logic [WAYS_W-1:0] b);
      logic [WAYS_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, COUNT_MOD}) begin
         sum = sum - {1'b0, COUNT_MOD};
      end
      return sum[WAYS_W-1:0];
   endfunction

   function automatic void clear_leaves();
      for (int i = 0; i < DOMAIN_SIZE_DEF; i++) begin
         leaf_len[i]  = 0;
         leaf_ways[i] = '0;
      end
   endfunction

   // Longest length and its summed count over the leaves below limit.
   function automatic void best_below(input int unsigned limit, output int unsigned top_len,
                                      output logic [WAYS_W-1:0] top_ways);
      top_len  = 0;
      top_ways = '0;
      for (int i = 0; i < limit; i++) begin
         if (leaf_len[i] > top_len) begin
            top_len  = leaf_len[i];
            top_ways = leaf_ways[i];
         end else if (leaf_len[i] == top_len) begin
            top_ways = add_ways(top_ways, leaf_ways[i]);
         end
      end
   endfunction

   // One element: extend the best run below it, merge into its leaf, report the overall best.
   function automatic lis_result_type count_lis_step(input logic [VALUE_W-1:0] value,
                                                     input logic start_new);
      int unsigned       pos;
      int unsigned       run_len;
      int unsigned       top_len;
      logic [WAYS_W-1:0] run_ways;
      logic [WAYS_W-1:0] top_ways;
      lis_result_type    res;
      if (start_new) begin
         clear_leaves();
      end
      pos = 32'(value);
      if (pos >= DOMAIN_SIZE_DEF) begin
         pos = DOMAIN_SIZE_DEF - 1;
      end
      best_below(pos, run_len, run_ways);
      if (run_len == 0) begin
         run_len  = 1;
         run_ways = WAYS_W'(1);
      end else begin
         run_len++;
      end
      if (run_len > leaf_len[pos]) begin
         leaf_len[pos]  = run_len;
         leaf_ways[pos] = run_ways;
      end else if (run_len == leaf_len[pos]) begin
         leaf_ways[pos] = add_ways(leaf_ways[pos], run_ways);
      end
      best_below(DOMAIN_SIZE_DEF, top_len, top_ways);
      res.len_here  = LEN_OUT_W'(run_len);
      res.ways_here = run_ways;
      res.best_len  = LEN_OUT_W'(top_len);
      res.best_ways = top_ways;
      return res;
   endfunction

   // Offer one request beat, after a random idle spell, and record its expectation once taken.
   task automatic send_item(input logic [VALUE_W-1:0] value, input logic start_new,
                            input logic known, input lis_result_type typed_result);
      lis_result_type predicted;
      while (!calm && $urandom_range(99) < 22) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.value     <= value;
      req_bus.start_new <= start_new;
      @(posedge clock);
      while (!req_bus.ready) begin
         @(posedge clock);
      end
      predicted = count_lis_step(value, start_new);
      lis_expected = {lis_expected, known ? typed_result : predicted};
      items_sent++;
   endtask

   // One random sequence of a randomly chosen shape.
   task automatic run_random_sequence();
      int unsigned seq_values [$];
      int          shape;
      int          count;
      int          base;
      int          span;
      int          width;
      int          steps;
      int          level;
      logic        fresh;
      shape = $urandom_range(99);
      fresh = ($urandom_range(9) != 0);
      if (shape < 30) begin
         // Values anywhere in the domain.
         count = $urandom_range(1, 40);
         repeat (count) seq_values = {seq_values, $urandom_range(1023)};
      end else if (shape < 50) begin
         // A narrow cluster, so that equal lengths pile up their counts.
         span  = $urandom_range(1, 16);
         base  = $urandom_range(0, 1024 - span);
         count = $urandom_range(5, 40);
         repeat (count) seq_values = {seq_values, base + $urandom_range(span - 1)};
      end else if (shape < 70) begin
         // A mostly rising walk with repeats and the odd drop.
         level = $urandom_range(200);
         count = $urandom_range(5, 40);
         repeat (count) begin
            seq_values = {seq_values, level};
            if ($urandom_range(9) == 0) begin
               level = $urandom_range(1023);
            end else begin
               level = level + $urandom_range(20);
               if (level > 1023) begin
                  level = 1023;
               end
            end
         end
      end else if (shape < 85) begin
         // Rising groups of falling values: counts grow geometrically and, on longer runs, wrap the modulus.
         width = $urandom_range(2, 3);
         steps = $urandom_range(15, 40);
         base  = $urandom_range(0, 1023 - width * steps);
         for (int s = 0; s < steps; s++) begin
            for (int j = 0; j < width; j++) begin
               seq_values = {seq_values, base + s * width + (width - 1 - j)};
            end
         end
      end else begin
         // Short noisy burst with restarts anywhere.
         count = $urandom_range(1, 10);
         repeat (count) seq_values = {seq_values, $urandom_range(1023)};
      end
      foreach (seq_values[i]) begin
         if (shape >= 85) begin
            send_item(VALUE_W'(seq_values[i]), 1'($urandom_range(1)), 1'b0, '0);
         end else begin
            send_item(VALUE_W'(seq_values[i]), (i == 0) && fresh, 1'b0, '0);
         end
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
         error_count++;
      end
   endtask

   // Response side: compare every accepted beat with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      lis_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (lis_expected.size() == 0) begin
            $display("%0t ns: unexpected response, expected none, got len_here %0d ways_here %0d",
                     $time, rsp_bus.len_here, rsp_bus.ways_here);
            error_count++;
         end else begin
            want = lis_expected.pop_front();
            check_field("len_here",  32'(want.len_here),  32'(rsp_bus.len_here));
            check_field("ways_here", 32'(want.ways_here), 32'(rsp_bus.ways_here));
            check_field("best_len",  32'(want.best_len),  32'(rsp_bus.best_len));
            check_field("best_ways", 32'(want.best_ways), 32'(rsp_bus.best_ways));
         end
      end
   end

   // Receiver: random stalls, one long hold-off once the tree is busy, none in the calm window.
   initial begin : rsp_ready_drive
      int  hold_left;
      bit  hold_done;
      hold_left     = 0;
      hold_done     = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (!hold_done && items_sent >= HOLD_AT) begin
            hold_left = HOLD_CYCLES - 1;
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= 22);
         end
      end
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   // Main sequence: reset, directed rows, random sequences, drain.
   initial begin : stimulus
      bit paused;
      paused            = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.value     = '0;
      req_bus.start_new = 1'b0;
      clear_leaves();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_item(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].start_new,
                   DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].result);
      end

      while (items_sent < TOTAL_ITEMS) begin
         // Once, let the block empty out completely before carrying on.
         if (!paused && items_sent >= PAUSE_AT) begin
            @(negedge clock);
            req_bus.valid <= 1'b0;
            while (lis_expected.size() != 0) @(negedge clock);
            paused = 1'b1;
         end
         run_random_sequence();
      end

      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (lis_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== lis_count_segment_tree.f =====
hw/rtl/lct_pkg.sv
hw/rtl/lct_if.sv
hw/rtl/lct_tree_mem.sv
hw/rtl/lct_combine.sv
hw/rtl/lis_count_segment_tree.sv
hw/rtl/lct_checker.sv
test/lis_count_segment_tree_tb.sv
